### src/pim_pkg.sv
package pim_pkg;

  localparam int FRAC_BITS = 16;
  localparam int STEP_FRAC = 16;
  localparam int WORD_W    = 32;
  localparam int STEP_W    = 16;

  localparam int N_ENT  = 16;
  localparam int AW     = 4;
  localparam int RC_W   = 2;
  localparam int N_SC   = 6;
  localparam int SC_W   = 3;
  localparam int CNT_W  = 7;
  localparam int TAG_W  = 6;

  // operands carry one extra bit so that negating the most negative word stays exact
  localparam int OPW    = WORD_W + 1;
  localparam int PROD_W = 2 * OPW;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int SSH_W  = PROD_W - STEP_FRAC;
  localparam int ACC_W  = SH_W + 2;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);
  localparam logic signed [WORD_W-1:0] ONE_FX   = WORD_W'(1 << FRAC_BITS);
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(N_SC);
  localparam logic [CNT_W-1:0] MAC_LAST   = CNT_W'(64);
  localparam logic [CNT_W-1:0] PF_CNT     = CNT_W'(4);
  localparam logic [AW:0]      EMIT_LAST  = (AW+1)'(N_ENT - 1);

  // scaled increment terms
  localparam logic [SC_W-1:0] SC_DX = 3'd0;
  localparam logic [SC_W-1:0] SC_DY = 3'd1;
  localparam logic [SC_W-1:0] SC_DZ = 3'd2;
  localparam logic [SC_W-1:0] SC_WX = 3'd3;
  localparam logic [SC_W-1:0] SC_WY = 3'd4;
  localparam logic [SC_W-1:0] SC_WZ = 3'd5;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MAC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic              sat;
    logic [WORD_W-1:0] val;
  } clip_t;

  typedef struct packed {
    logic [AW-1:0]     idx;
    logic [WORD_W-1:0] val;
    logic              last;
    logic              sat;
  } out_beat_t;

  function automatic clip_t clip_word(input logic signed [ACC_W-1:0] x);
    clip_t r;
    r.sat = 1'b0;
    r.val = x[WORD_W-1:0];
    if (x > ACC_W'(WORD_MAX)) begin
      r.sat = 1'b1;
      r.val = WORD_MAX;
    end else if (x < ACC_W'(WORD_MIN)) begin
      r.sat = 1'b1;
      r.val = WORD_MIN;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pose_reset(input logic [AW-1:0] a);
    return (a[RC_W-1:0] == a[AW-1:RC_W]) ? ONE_FX : '0;
  endfunction

endpackage

### src/pose_increment_update_top.sv
// Pose integrator: holds a 4x4 Q16.16 homogeneous pose (identity after reset) and on a step
// command replaces it by Trans(d) * (I + skew(w)) * pose, where d and w are the velocities
// times the configured time step (Q0.16 s), then sends all 16 entries in row order, the last
// beat flagged. A load command writes one pose entry in its accept cycle and sends nothing.
// A step keeps the input stalled until its last pose read is issued: first the six velocities
// are scaled, then the 64 matrix products are formed, both through one shared 33x33 multiplier
// issuing one product per cycle, then the 16 pose entries are read from memory into a two-beat
// output buffer, reads held back while it is full. Results of one step may still be
// draining while the next item is accepted.
module pose_increment_update_top (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 cfg_wr_en,
  input  logic [pim_pkg::STEP_W-1:0]           cfg_wr_data,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [3:0]                           in_entry_index,
  input  logic signed [pim_pkg::WORD_W-1:0]    in_entry_value,
  input  logic signed [pim_pkg::WORD_W-1:0]    in_lin_vel_x,
  input  logic signed [pim_pkg::WORD_W-1:0]    in_lin_vel_y,
  input  logic signed [pim_pkg::WORD_W-1:0]    in_lin_vel_z,
  input  logic signed [pim_pkg::WORD_W-1:0]    in_ang_vel_x,
  input  logic signed [pim_pkg::WORD_W-1:0]    in_ang_vel_y,
  input  logic signed [pim_pkg::WORD_W-1:0]    in_ang_vel_z,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [3:0]                           out_index,
  output logic signed [pim_pkg::WORD_W-1:0]    out_value,
  output logic                                 out_last_entry,
  output logic                                 out_saturated
);

  pim_pkg::state_t state_r, state_nxt;
  logic [pim_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pim_pkg::AW:0]      em_cnt_r;
  logic [pim_pkg::STEP_W-1:0] step_r;

  logic signed [pim_pkg::WORD_W-1:0] vel_r [pim_pkg::N_SC];
  logic signed [pim_pkg::WORD_W-1:0] sc_r  [pim_pkg::N_SC];
  logic signed [pim_pkg::WORD_W-1:0] col_r [4];
  logic signed [pim_pkg::WORD_W-1:0] colp_r [4];

  logic in_acc;
  logic sc_issue, mac_issue, pf_issue, col_copy, em_issue;
  logic [pim_pkg::RC_W-1:0] mi, mj, mk;

  logic signed [pim_pkg::OPW-1:0]    mul_a, mul_b, m_ent;
  logic signed [pim_pkg::PROD_W-1:0] prod_nxt, prod_r;
  logic                              prod_sc_r, prod_mac_r;
  logic [pim_pkg::TAG_W-1:0]         ptag_r;
  logic [pim_pkg::RC_W-1:0]          pi, pj, pk;

  logic signed [pim_pkg::SH_W-1:0]   sh_mac;
  logic signed [pim_pkg::SSH_W-1:0]  sh_sc;
  logic signed [pim_pkg::ACC_W-1:0]  acc_r, acc_sum;
  pim_pkg::clip_t                    mac_clip, sc_clip;
  logic [pim_pkg::N_ENT-1:0]         sat_r;

  pim_pkg::mem_req_t         mreq;
  logic [pim_pkg::WORD_W-1:0] rd_data;
  logic                       pf_vld_r;
  logic [pim_pkg::RC_W-1:0]   pf_k_r;

  logic                   em_pend_r;
  logic [pim_pkg::AW-1:0] em_idx_r;
  pim_pkg::out_beat_t     pend_beat, out_r, out_nxt, skid_r, skid_nxt;
  logic                   out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt, out_free;

  assign in_acc = in_valid && !in_stall;
  assign mj = cnt_r[5:4];
  assign mi = cnt_r[3:2];
  assign mk = cnt_r[1:0];
  assign pj = ptag_r[5:4];
  assign pi = ptag_r[3:2];
  assign pk = ptag_r[1:0];

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pim_pkg::ST_IDLE:  if (in_acc && in_command == pim_pkg::CMD_STEP) state_nxt = pim_pkg::ST_SCALE;
      pim_pkg::ST_SCALE: if (cnt_r == pim_pkg::SCALE_LAST) state_nxt = pim_pkg::ST_MAC;
      pim_pkg::ST_MAC:   if (cnt_r == pim_pkg::MAC_LAST) state_nxt = pim_pkg::ST_EMIT;
      pim_pkg::ST_EMIT:  if (em_issue && em_cnt_r == pim_pkg::EMIT_LAST) state_nxt = pim_pkg::ST_IDLE;
      default:           state_nxt = pim_pkg::ST_IDLE;
    endcase
  end

  assign cnt_nxt = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;

  always_comb begin
    in_stall  = 1'b1;
    sc_issue  = 1'b0;
    mac_issue = 1'b0;
    pf_issue  = 1'b0;
    col_copy  = 1'b0;
    em_issue  = 1'b0;
    unique case (state_r)
      pim_pkg::ST_IDLE:  in_stall = 1'b0;
      pim_pkg::ST_SCALE: begin
        sc_issue = cnt_r < pim_pkg::SCALE_LAST;
        pf_issue = cnt_r < pim_pkg::PF_CNT;
        col_copy = cnt_r == pim_pkg::SCALE_LAST;
      end
      pim_pkg::ST_MAC: begin
        mac_issue = cnt_r < pim_pkg::MAC_LAST;
        // prefetch next column during the first four products of this one
        pf_issue  = mac_issue && cnt_r[3:2] == '0 && mj != '1;
        col_copy  = mac_issue && cnt_r[3:0] == '1;
      end
      pim_pkg::ST_EMIT:  em_issue = !(out_vld_nxt && skid_vld_nxt);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pim_pkg::ST_IDLE;
      cnt_r    <= '0;
      em_cnt_r <= '0;
      step_r   <= pim_pkg::STEP_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r != pim_pkg::ST_EMIT) begin
        em_cnt_r <= '0;
      end else if (em_issue) begin
        em_cnt_r <= em_cnt_r + 1'b1;
      end
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      vel_r[pim_pkg::SC_DX] <= in_lin_vel_x;
      vel_r[pim_pkg::SC_DY] <= in_lin_vel_y;
      vel_r[pim_pkg::SC_DZ] <= in_lin_vel_z;
      vel_r[pim_pkg::SC_WX] <= in_ang_vel_x;
      vel_r[pim_pkg::SC_WY] <= in_ang_vel_y;
      vel_r[pim_pkg::SC_WZ] <= in_ang_vel_z;
    end
  end

  // ---------------- increment matrix entry (mi, mk) ----------------
  always_comb begin
    unique case ({mi, mk})
      4'h0, 4'h5, 4'ha, 4'hf: m_ent = pim_pkg::OPW'(pim_pkg::ONE_FX);
      4'h1: m_ent = -pim_pkg::OPW'(sc_r[pim_pkg::SC_WZ]);
      4'h2: m_ent =  pim_pkg::OPW'(sc_r[pim_pkg::SC_WY]);
      4'h3: m_ent =  pim_pkg::OPW'(sc_r[pim_pkg::SC_DX]);
      4'h4: m_ent =  pim_pkg::OPW'(sc_r[pim_pkg::SC_WZ]);
      4'h6: m_ent = -pim_pkg::OPW'(sc_r[pim_pkg::SC_WX]);
      4'h7: m_ent =  pim_pkg::OPW'(sc_r[pim_pkg::SC_DY]);
      4'h8: m_ent = -pim_pkg::OPW'(sc_r[pim_pkg::SC_WY]);
      4'h9: m_ent =  pim_pkg::OPW'(sc_r[pim_pkg::SC_WX]);
      4'hb: m_ent =  pim_pkg::OPW'(sc_r[pim_pkg::SC_DZ]);
      default: m_ent = '0;
    endcase
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (sc_issue) begin
      mul_a = pim_pkg::OPW'(vel_r[cnt_r[pim_pkg::SC_W-1:0]]);
      mul_b = pim_pkg::OPW'($signed({1'b0, step_r}));
    end else if (mac_issue) begin
      mul_a = m_ent;
      mul_b = pim_pkg::OPW'(col_r[mk]);
    end
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    ptag_r <= cnt_r[pim_pkg::TAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_sc_r  <= 1'b0;
      prod_mac_r <= 1'b0;
    end else begin
      prod_sc_r  <= sc_issue;
      prod_mac_r <= mac_issue;
    end
  end

  // ---------------- shift, accumulate, saturate ----------------
  assign sh_mac   = prod_r[pim_pkg::PROD_W-1:pim_pkg::FRAC_BITS];
  assign sh_sc    = prod_r[pim_pkg::PROD_W-1:pim_pkg::STEP_FRAC];
  assign acc_sum  = ((pk == '0) ? '0 : acc_r) + pim_pkg::ACC_W'(sh_mac);
  assign mac_clip = pim_pkg::clip_word(acc_sum);
  assign sc_clip  = pim_pkg::clip_word(pim_pkg::ACC_W'(sh_sc));

  always_ff @(posedge clk) begin
    if (prod_mac_r) begin
      acc_r <= acc_sum;
      if (pk == '1) begin
        sat_r[{pi, pj}] <= mac_clip.sat;
      end
    end
    if (prod_sc_r) begin
      sc_r[ptag_r[pim_pkg::SC_W-1:0]] <= sc_clip.val;
    end
  end

  // ---------------- pose memory ----------------
  always_comb begin
    mreq.wr_en   = 1'b0;
    mreq.wr_addr = in_entry_index;
    mreq.wr_data = in_entry_value;
    if (in_acc && in_command == pim_pkg::CMD_LOAD) begin
      mreq.wr_en = 1'b1;
    end else if (prod_mac_r && pk == '1) begin
      mreq.wr_en   = 1'b1;
      mreq.wr_addr = {pi, pj};
      mreq.wr_data = mac_clip.val;
    end
    if (state_r == pim_pkg::ST_EMIT) begin
      mreq.rd_addr = em_cnt_r[pim_pkg::AW-1:0];
    end else if (state_r == pim_pkg::ST_MAC) begin
      mreq.rd_addr = {mk, mj + 1'b1};
    end else begin
      mreq.rd_addr = {cnt_r[pim_pkg::RC_W-1:0], pim_pkg::RC_W'(0)};
    end
  end

  pim_pose_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mreq),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_vld_r  <= 1'b0;
      em_pend_r <= 1'b0;
    end else begin
      pf_vld_r  <= pf_issue;
      em_pend_r <= em_issue;
    end
  end

  always_ff @(posedge clk) begin
    pf_k_r   <= mreq.rd_addr[pim_pkg::AW-1:pim_pkg::RC_W];
    em_idx_r <= mreq.rd_addr;
    if (pf_vld_r) begin
      colp_r[pf_k_r] <= rd_data;
    end
    if (col_copy) begin
      col_r <= colp_r;
    end
  end

  // ---------------- output buffer: output register plus skid beat ----------------
  assign pend_beat.idx  = em_idx_r;
  assign pend_beat.val  = rd_data;
  assign pend_beat.last = em_idx_r == '1;
  assign pend_beat.sat  = sat_r[em_idx_r];
  assign out_free       = !out_vld_r || !out_stall;

  always_comb begin
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_free) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_nxt     = pend_beat;
        skid_vld_nxt = em_pend_r;
      end else begin
        out_nxt     = pend_beat;
        out_vld_nxt = em_pend_r;
      end
    end else if (em_pend_r) begin
      skid_nxt     = pend_beat;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid      = out_vld_r;
  assign out_index      = out_r.idx;
  assign out_value      = out_r.val;
  assign out_last_entry = out_r.last;
  assign out_saturated  = out_r.sat;

endmodule

### src/pim_pose_mem.sv
module pim_pose_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pim_pkg::mem_req_t             req,
  output logic [pim_pkg::WORD_W-1:0]    rd_data
);

  logic [pim_pkg::WORD_W-1:0] mem [pim_pkg::N_ENT];
  logic [pim_pkg::N_ENT-1:0]  vld_r;
  logic [pim_pkg::WORD_W-1:0] rd_q_r;
  logic                       rd_vld_r;
  logic [pim_pkg::AW-1:0]     rd_addr_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_q_r    <= mem[req.rd_addr];
    rd_addr_r <= req.rd_addr;
  end

  // entries never written since reset read as the identity pose
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : pim_pkg::pose_reset(rd_addr_r);

endmodule
